// ----- hdl/tss_pkg.sv -----
// tss_pkg: shared command codes, literal and variable index widths and
// sequencer state type for the 2-SAT solver. No dependencies.
package tss_pkg;

	localparam int LIT_W = 6;
	localparam int VAR_W = 5;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_SOLVE = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_VAR      = 9'b000000010,
		ST_WSTART   = 9'b000000100,
		ST_RD       = 9'b000001000,
		ST_CHK      = 9'b000010000,
		ST_POPW     = 9'b000100000,
		ST_UNDO_RD  = 9'b001000000,
		ST_UNDO_CLR = 9'b010000000,
		ST_EMIT     = 9'b100000000
	} state_t;

endpackage

// ----- hdl/tss_ram.sv -----
// tss_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
module tss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/two_sat_solver.sv -----
// two_sat_solver: 2-SAT solver, depth-first assignment with rollback.
// Depends on tss_pkg and tss_ram (clause store, walk stack, trail).
//
// channel  | dir | handshake           | payload
// in       | in  | in_valid/in_ready   | cmd, lit_p, lit_q
// out      | out | out_valid/out_ready | var_index, value, satisfiable, clause_error, last
// cfg      | in  | cfg_valid/cfg_ready | cfg_data (num_vars)
//
// Add, clear and unknown commands complete in ST_IDLE. A solve runs the walk
// sequencer: each stored edge examined per stack frame passes ST_RD (clause
// RAM read) then ST_CHK (compare), each pop ST_RD then ST_POPW, each trail
// entry undone ST_UNDO_RD then ST_UNDO_CLR, then one result per cycle while
// out_ready is high. in_ready is low from solve transfer until the last result
// transfer. Reset clears counters, flags, marks and num_vars (to 32); RAM contents need no reset.
module two_sat_solver #(
	parameter int MAX_VARS    = 32,
	parameter int MAX_CLAUSES = 128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   cmd,
	input  logic [tss_pkg::LIT_W-1:0]    lit_p,
	input  logic [tss_pkg::LIT_W-1:0]    lit_q,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tss_pkg::VAR_W-1:0]    var_index,
	output logic                         value,
	output logic                         satisfiable,
	output logic                         clause_error,
	output logic                         last,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tss_pkg::LIT_W-1:0]    cfg_data
);
	import tss_pkg::*;

	localparam int NLIT  = 2 * MAX_VARS;
	localparam int LW    = $clog2(NLIT);
	localparam int SPW   = $clog2(NLIT + 1);
	localparam int VIW   = $clog2(MAX_VARS + 1);
	localparam int CAW   = MAX_CLAUSES > 1 ? $clog2(MAX_CLAUSES) : 1;
	localparam int CCW   = $clog2(MAX_CLAUSES + 1);
	localparam int EW    = $clog2(2 * MAX_CLAUSES + 1);
	localparam int EDW   = 2 * LIT_W;

	state_t              state_q;
	logic [LIT_W-1:0]    nv_raw_q;
	logic [CCW-1:0]      cl_count_q;
	logic                err_q;
	logic                sat_q;
	logic [NLIT-1:0]     marks_q;
	logic [VIW-1:0]      var_i_q;
	logic                try_q;
	logic [LW-1:0]       top_node_q;
	logic [EW-1:0]       top_pos_q;
	logic [SPW-1:0]      sp_q;
	logic [SPW-1:0]      trail_len_q;
	logic [SPW-1:0]      undo_j_q;

	// effective variable count and literal limit
	logic [LIT_W-1:0]    nv;
	logic [LIT_W:0]      nlit;
	always_comb begin
		if (nv_raw_q == '0) begin
			nv = LIT_W'(1);
		end else if (nv_raw_q > LIT_W'(MAX_VARS)) begin
			nv = LIT_W'(MAX_VARS);
		end else begin
			nv = nv_raw_q;
		end
		nlit = {nv, 1'b0};
	end

	// clause store: each clause takes a row holding both of its edges {from, to}
	logic                cl_we;
	logic [2*EDW-1:0]    cl_wdata;
	logic [2*EDW-1:0]    cl_rdata;
	logic [CAW-1:0]      cl_raddr;
	assign cl_wdata = {lit_q ^ LIT_W'(1), lit_p, lit_p ^ LIT_W'(1), lit_q};
	assign cl_raddr = top_pos_q[CAW:1];

	tss_ram #(.WIDTH(2 * EDW), .DEPTH(MAX_CLAUSES)) u_clause_ram (
		.clk   (clk),
		.we    (cl_we),
		.waddr (cl_count_q[CAW-1:0]),
		.wdata (cl_wdata),
		.raddr (cl_raddr),
		.rdata (cl_rdata)
	);

	// walk stack: frames below the top one, {node, next edge}
	logic                stk_we;
	logic [LW+EW-1:0]    stk_wdata;
	logic [LW+EW-1:0]    stk_rdata;
	logic [LW-1:0]       stk_waddr;
	logic [LW-1:0]       stk_raddr;
	logic [SPW-1:0]      sp_dec;
	logic [SPW-1:0]      sp_dec2;
	logic [EW-1:0]       next_pos;
	assign next_pos  = top_pos_q + EW'(1);
	assign sp_dec    = sp_q - SPW'(1);
	assign sp_dec2   = sp_q - SPW'(2);
	assign stk_wdata = {top_node_q, next_pos};
	assign stk_waddr = sp_dec[LW-1:0];
	assign stk_raddr = sp_dec2[LW-1:0];

	tss_ram #(.WIDTH(LW + EW), .DEPTH(NLIT)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// trail: literals marked by the current walk attempt
	logic                trl_we;
	logic [LW-1:0]       trl_wdata;
	logic [LW-1:0]       trl_rdata;

	tss_ram #(.WIDTH(LW), .DEPTH(NLIT)) u_trail_ram (
		.clk   (clk),
		.we    (trl_we),
		.waddr (trail_len_q[LW-1:0]),
		.wdata (trl_wdata),
		.raddr (undo_j_q[LW-1:0]),
		.rdata (trl_rdata)
	);

	// edge decode for the compare step
	logic [EDW-1:0]      edge_w;
	logic [LIT_W-1:0]    e_from;
	logic [LIT_W-1:0]    e_to;
	logic [LW-1:0]       to_l;
	logic                e_hit;
	logic [EW-1:0]       edge_count;
	assign edge_w     = top_pos_q[0] ? cl_rdata[2*EDW-1:EDW] : cl_rdata[EDW-1:0];
	assign e_from     = edge_w[EDW-1:LIT_W];
	assign e_to       = edge_w[LIT_W-1:0];
	assign to_l       = e_to[LW-1:0];
	assign e_hit      = (e_from == LIT_W'(top_node_q)) && ({1'b0, e_from} < nlit)
		&& ({1'b0, e_to} < nlit);
	assign edge_count = EW'({cl_count_q, 1'b0});

	// start literal and clause range checks
	logic [VIW:0]        start_w;
	logic [LW-1:0]       start_l;
	logic [LW-1:0]       odd_l;
	logic                add_bad;
	assign start_w = {var_i_q, try_q};
	assign start_l = start_w[LW-1:0];
	logic [VIW:0]        odd_w;
	assign odd_w   = {var_i_q, 1'b1};
	assign odd_l   = odd_w[LW-1:0];
	assign add_bad = ((lit_p >> 1) >= nv) || ((lit_q >> 1) >= nv)
		|| (cl_count_q == CCW'(MAX_CLAUSES));

	// handshakes and outputs
	logic in_xfer;
	logic out_xfer;
	assign in_ready     = (state_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign in_xfer      = in_valid && in_ready;
	assign out_valid    = (state_q == ST_EMIT);
	assign out_xfer     = out_valid && out_ready;
	assign var_index    = VAR_W'(var_i_q);
	assign value        = sat_q && marks_q[odd_l];
	assign satisfiable  = sat_q;
	assign clause_error = err_q;
	assign last         = !sat_q || (LIT_W'(var_i_q) + LIT_W'(1) == nv);

	assign cl_we     = in_xfer && (cmd_t'(cmd) == CMD_ADD) && !add_bad;
	assign stk_we    = (state_q == ST_CHK) && e_hit && !marks_q[to_l ^ LW'(1)]
		&& !marks_q[to_l];
	assign trl_we    = ((state_q == ST_WSTART) && !marks_q[start_l ^ LW'(1)]
		&& !marks_q[start_l] && (trail_len_q < SPW'(NLIT)))
		|| (stk_we && (trail_len_q < SPW'(NLIT)));
	assign trl_wdata = (state_q == ST_WSTART) ? start_l : to_l;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_raw_q <= LIT_W'(32);
		end else if (cfg_valid && cfg_ready) begin
			nv_raw_q <= cfg_data;
		end
	end

	// walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cl_count_q  <= '0;
			err_q       <= 1'b0;
			sat_q       <= 1'b0;
			marks_q     <= '0;
			var_i_q     <= '0;
			try_q       <= 1'b0;
			top_node_q  <= '0;
			top_pos_q   <= '0;
			sp_q        <= '0;
			trail_len_q <= '0;
			undo_j_q    <= '0;
		end else begin
			if (trl_we) begin
				trail_len_q <= trail_len_q + SPW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (cmd_t'(cmd))
							CMD_ADD: begin
								if (add_bad) begin
									err_q <= 1'b1;
								end else begin
									cl_count_q <= cl_count_q + CCW'(1);
								end
							end
							CMD_SOLVE: begin
								marks_q <= '0;
								var_i_q <= '0;
								state_q <= ST_VAR;
							end
							CMD_CLEAR: begin
								cl_count_q <= '0;
								err_q      <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_VAR: begin
					if (LIT_W'(var_i_q) == nv) begin
						sat_q   <= 1'b1;
						var_i_q <= '0;
						state_q <= ST_EMIT;
					end else if (marks_q[start_w[LW-1:0] & ~LW'(1)] || marks_q[odd_l]) begin
						var_i_q <= var_i_q + VIW'(1);
					end else begin
						try_q       <= 1'b0;
						trail_len_q <= '0;
						state_q     <= ST_WSTART;
					end
				end
				ST_WSTART: begin
					if (marks_q[start_l ^ LW'(1)]) begin
						// conflict at the start literal
						if (try_q) begin
							sat_q   <= 1'b0;
							var_i_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							undo_j_q <= '0;
							state_q  <= ST_UNDO_RD;
						end
					end else if (marks_q[start_l]) begin
						var_i_q <= var_i_q + VIW'(1);
						state_q <= ST_VAR;
					end else begin
						marks_q[start_l] <= 1'b1;
						top_node_q       <= start_l;
						top_pos_q        <= '0;
						sp_q             <= SPW'(1);
						state_q          <= ST_RD;
					end
				end
				ST_RD: begin
					if (top_pos_q >= edge_count) begin
						// frame exhausted: pop
						sp_q <= sp_dec;
						if (sp_q == SPW'(1)) begin
							var_i_q <= var_i_q + VIW'(1);
							state_q <= ST_VAR;
						end else begin
							state_q <= ST_POPW;
						end
					end else begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					state_q <= ST_RD;
					if (e_hit && marks_q[to_l ^ LW'(1)]) begin
						if (try_q) begin
							sat_q   <= 1'b0;
							var_i_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							undo_j_q <= '0;
							state_q  <= ST_UNDO_RD;
						end
					end else if (stk_we) begin
						// push a frame for the new literal
						marks_q[to_l] <= 1'b1;
						top_node_q    <= to_l;
						top_pos_q     <= '0;
						sp_q          <= sp_q + SPW'(1);
					end else begin
						top_pos_q <= next_pos;
					end
				end
				ST_POPW: begin
					top_node_q <= stk_rdata[LW+EW-1:EW];
					top_pos_q  <= stk_rdata[EW-1:0];
					state_q    <= ST_RD;
				end
				ST_UNDO_RD: begin
					if (undo_j_q == trail_len_q) begin
						try_q       <= 1'b1;
						trail_len_q <= '0;
						state_q     <= ST_WSTART;
					end else begin
						state_q <= ST_UNDO_CLR;
					end
				end
				ST_UNDO_CLR: begin
					marks_q[trl_rdata] <= 1'b0;
					undo_j_q           <= undo_j_q + SPW'(1);
					state_q            <= ST_UNDO_RD;
				end
				ST_EMIT: begin
					if (out_xfer) begin
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							var_i_q <= var_i_q + VIW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(NLIT)) else $error("walk stack overflow");
	a_trail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		trail_len_q <= SPW'(NLIT)) else $error("trail overflow");
	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cl_count_q <= CCW'(MAX_CLAUSES)) else $error("clause count past capacity");
	a_unsat_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !satisfiable) |-> (last && var_index == '0 && !value))
		else $error("unsatisfiable result malformed");
	a_busy_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while results pending");
endmodule

// ----- test/tb.sv -----
// tb: self-checking testbench for two_sat_solver (2-SAT, depth-first assignment).
// Depends on tss_pkg and the two_sat_solver RTL; carries its own solver predictor.
`timescale 1ns / 100ps

module tb;
	import tss_pkg::*;

	localparam int NV_MAX   = 32;
	localparam int NEDGE    = 256;
	localparam int NLITS    = 64;

	typedef struct packed {
		logic [1:0] cmd;
		logic [5:0] p;
		logic [5:0] q;
	} clause_cmd_t;

	typedef struct packed {
		logic [4:0] var_index;
		logic       value;
		logic       satisfiable;
		logic       clause_error;
		logic       last;
	} assign_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = 2'd0;
	logic [5:0] lit_p = 6'd0;
	logic [5:0] lit_q = 6'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [4:0] var_index;
	logic value, satisfiable, clause_error, last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [5:0] cfg_data = 6'd0;

	two_sat_solver u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .lit_p(lit_p), .lit_q(lit_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.var_index(var_index), .value(value), .satisfiable(satisfiable),
		.clause_error(clause_error), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [5:0]  pr_nvars;
	logic [11:0] pr_edges [NEDGE];
	int          pr_ecount;
	logic        pr_err;
	logic        pr_mark [NLITS];
	logic [5:0]  pr_trail [$];

	clause_cmd_t pending_cmds [$];
	assign_t     expected_assign [$];
	int          fail_count = 0;
	bit          quiet_in = 1'b0;   // sender idle lanes
	bit          calm = 1'b0;       // no random idling
	bit          hold_out = 0;
	int          hold_cycles = 0;

	function automatic int eff_nvars();
		if (pr_nvars == 0) return 1;
		if (pr_nvars > NV_MAX) return NV_MAX;
		return pr_nvars;
	endfunction

	function automatic void set_mark(int lit);
		pr_mark[lit] = 1'b1;
		pr_trail = {pr_trail, lit[5:0]};
	endfunction

	// depth-first implication walk; 0 on conflict
	function automatic bit implication_walk(int start, int nlit);
		int node_s [$];
		int pos_s [$];
		int k, dst, src, top;
		bit hit;
		if (pr_mark[start ^ 1]) return 0;
		if (pr_mark[start]) return 1;
		set_mark(start);
		node_s = {node_s, start};
		pos_s = {pos_s, 0};
		while (node_s.size() > 0) begin
			top = node_s.size() - 1;
			k = pos_s[top];
			hit = 0;
			dst = 0;
			while (k < pr_ecount) begin
				src = pr_edges[k][11:6];
				dst = pr_edges[k][5:0];
				k++;
				if (src == node_s[top] && src < nlit && dst < nlit) begin
					hit = 1;
					break;
				end
			end
			pos_s[top] = k;
			if (!hit) begin
				void'(node_s.pop_back());
				void'(pos_s.pop_back());
				continue;
			end
			if (pr_mark[dst ^ 1]) return 0;
			if (pr_mark[dst]) continue;
			set_mark(dst);
			if (node_s.size() < NLITS) begin
				node_s = {node_s, dst};
				pos_s = {pos_s, 0};
			end
		end
		return 1;
	endfunction

	function automatic void predict_solver(clause_cmd_t c);
		int nv, nlit;
		bit ok;
		assign_t r;
		nv = eff_nvars();
		nlit = 2 * nv;
		case (c.cmd)
			CMD_ADD: begin
				if ((c.p >> 1) >= nv || (c.q >> 1) >= nv || pr_ecount + 2 > NEDGE)
					pr_err = 1'b1;
				else begin
					pr_edges[pr_ecount] = {c.p ^ 6'd1, c.q};
					pr_edges[pr_ecount + 1] = {c.q ^ 6'd1, c.p};
					pr_ecount += 2;
				end
			end
			CMD_CLEAR: begin
				pr_ecount = 0;
				pr_err = 1'b0;
			end
			CMD_SOLVE: begin
				ok = 1;
				foreach (pr_mark[i]) pr_mark[i] = 1'b0;
				for (int i = 0; i < nlit && ok; i += 2) begin
					if (pr_mark[i] || pr_mark[i + 1]) continue;
					pr_trail.delete();
					if (!implication_walk(i, nlit)) begin
						foreach (pr_trail[j]) pr_mark[pr_trail[j]] = 1'b0;
						pr_trail.delete();
						if (!implication_walk(i + 1, nlit)) ok = 0;
					end
				end
				if (!ok) begin
					r = '{5'd0, 1'b0, 1'b0, pr_err, 1'b1};
					expected_assign = {expected_assign, r};
				end else begin
					for (int i = 0; i < nv; i++) begin
						r = '{i[4:0], pr_mark[2 * i + 1], 1'b1, pr_err, (i + 1 == nv)};
						expected_assign = {expected_assign, r};
					end
				end
			end
			default: ;
		endcase
	endfunction

	// driver: presents queued commands, predicts on each transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) predict_solver({cmd, lit_p, lit_q});
			if (!in_valid || in_ready) begin
				if (pending_cmds.size() > 0 && !quiet_in &&
						(calm || $urandom_range(99) >= 6)) begin
					in_valid <= 1'b1;
					{cmd, lit_p, lit_q} <= pending_cmds.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transfer against the oldest expectation
	always @(posedge clk) begin
		assign_t got, want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{var_index, value, satisfiable, clause_error, last};
				if (expected_assign.size() == 0) begin
					$display("%0t: unexpected result %p", $time, got);
					fail_count++;
				end else begin
					want = expected_assign.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
						fail_count++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_ready <= 1'b0;
			end else if (hold_out) begin
				hold_out <= 1'b0;
				hold_cycles <= 300;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || $urandom_range(99) >= 6;
			end
		end
	end

	task automatic queue_cmd(cmd_t c, int p, int q);
		clause_cmd_t item;
		item = '{c, p[5:0], q[5:0]};
		pending_cmds = {pending_cmds, item};
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || in_valid || expected_assign.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_nvars(int n);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= n[5:0];
		do @(posedge clk); while (!cfg_ready);
		pr_nvars = n[5:0];
		cfg_valid <= 1'b0;
	endtask

	// random phase: mostly well-formed clause sets, then a solve
	task automatic random_sets(int n_items, int nv_hi);
		int c;
		c = 0;
		while (c < n_items) begin
			int nv, ncl;
			nv = $urandom_range(nv_hi, 1);
			if ($urandom_range(3) == 0) begin
				queue_cmd(CMD_CLEAR, $urandom_range(63), $urandom_range(63));
				c++;
			end
			ncl = $urandom_range(2 * nv + 2, 1);
			for (int i = 0; i < ncl; i++) begin
				if ($urandom_range(15) == 0)
					queue_cmd(CMD_ADD, $urandom_range(63), $urandom_range(63));
				else
					queue_cmd(CMD_ADD, $urandom_range(2 * nv - 1), $urandom_range(2 * nv - 1));
				c++;
			end
			if ($urandom_range(9) == 0) begin
				queue_cmd(CMD_NONE, $urandom_range(63), $urandom_range(63));
			end
			queue_cmd(CMD_SOLVE, $urandom_range(63), $urandom_range(63));
			c++;
		end
	endtask

	initial begin
		pr_nvars = 6'd32;
		pr_ecount = 0;
		pr_err = 1'b0;
		foreach (pr_mark[i]) pr_mark[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty store, extremes, unsat, clear, unknown
		queue_cmd(CMD_SOLVE, 0, 0);
		queue_cmd(CMD_ADD, 0, 0);
		queue_cmd(CMD_ADD, 1, 1);
		queue_cmd(CMD_SOLVE, 63, 63);
		queue_cmd(CMD_CLEAR, 63, 0);
		queue_cmd(CMD_ADD, 63, 62);
		queue_cmd(CMD_ADD, 1, 2);
		queue_cmd(CMD_ADD, 3, 62);
		queue_cmd(CMD_NONE, 63, 63);
		queue_cmd(CMD_SOLVE, 0, 63);
		queue_cmd(CMD_CLEAR, 0, 0);
		drain();

		write_nvars(1);
		queue_cmd(CMD_ADD, 2, 0);
		queue_cmd(CMD_ADD, 1, 1);
		queue_cmd(CMD_SOLVE, 0, 0);
		drain();
		write_nvars(0);
		queue_cmd(CMD_SOLVE, 0, 0);
		queue_cmd(CMD_CLEAR, 0, 0);
		drain();
		write_nvars(63);
		// fill store past capacity
		calm = 1;
		for (int i = 0; i < 130; i++) queue_cmd(CMD_ADD, i % 64, (i * 7) % 64);
		queue_cmd(CMD_SOLVE, 0, 0);
		drain();
		// stale edges after shrinking the variable count
		write_nvars(4);
		queue_cmd(CMD_SOLVE, 0, 0);
		queue_cmd(CMD_CLEAR, 0, 0);
		drain();
		calm = 0;

		// receiver holds off while sender keeps offering
		write_nvars(8);
		random_sets(40, 8);
		hold_out = 1;
		drain();

		// sender pause, then random bulk
		quiet_in = 1;
		repeat (30) @(posedge clk);
		quiet_in = 0;
		random_sets(100, 6);
		drain();
		write_nvars(32);
		calm = 1;
		random_sets(60, 32);
		drain();
		calm = 0;
		write_nvars(12);
		random_sets(110, 12);
		drain();
		write_nvars(3);
		random_sets(30, 3);
		drain();

		if (fail_count == 0)
			$display("[two_sat_solver] OK");
		else
			$display("[two_sat_solver] ERROR");
		$finish;
	end

	initial begin
		#100ms;
		$display("[two_sat_solver] ERROR");
		$finish;
	end

endmodule
